// File: design/dhbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbd_pkg
// Types, widths and constants shared by the box decoder files.
// ----------------------------------------------------------------------------
package dhbd_pkg;

   localparam int MAX_CLASSES_DEF = 128;
   localparam int MAX_GRID_DEF    = 128;

   localparam int LOGIT_W   = 16;
   localparam int DIST_W    = 16;
   localparam int BOX_W     = 17;
   localparam int LABEL_W   = 7;
   localparam int SCORE_W   = 16;
   localparam int INDEX_W   = 7;
   localparam int GW_W      = 8;
   localparam int STRIDE_W  = 7;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_STRIDE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = 2'd2;

   localparam logic [GW_W-1:0]     GRID_WIDTH_RESET      = 8'd80;
   localparam logic [STRIDE_W-1:0] CELL_STRIDE_RESET     = 7'd8;
   localparam logic [SCORE_W-1:0]  SCORE_THRESHOLD_RESET = 16'd26214;

   // Sigmoid exponent argument, Q.24 with the float bias folded in.
   localparam int S_W = 34;
   localparam logic signed [17:0]    LOG2E_Q16   = 18'sd94548;
   localparam logic signed [S_W-1:0] EXP_BIAS_X2 = 34'sd2129614322;

   localparam int EXP_W   = 9;
   localparam int MANT_W  = 24;
   localparam logic [EXP_W-1:0] EXP_HI  = 9'd143;
   localparam logic [EXP_W-1:0] EXP_LO  = 9'd87;
   localparam logic [EXP_W-1:0] EXP_REF = 9'd110;

   // Divider: quotient of 2^56 by a denominator of at least 2^40.
   localparam int DEN_W      = 58;
   localparam int DEN_ONE    = 40;
   localparam int REM_INIT   = 39;
   localparam int QUO_W      = 17;
   localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

   localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

   localparam int BOX_CALC_W = 22;

   typedef struct packed {
      logic               bypass;
      logic [SCORE_W-1:0] bypass_score;
      logic [DEN_W-1:0]   den;
   } expo_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic div_start;
      logic commit;
   } ctrl_type;

endpackage

// File: design/dhbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbd_if
// Request and response channels of the box decoder.
// ----------------------------------------------------------------------------
interface dhbd_req_if import dhbd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [LOGIT_W-1:0] class_logit;
   logic                      last_class;
   logic                      frame_start;
   logic signed [DIST_W-1:0]  dist_left;
   logic signed [DIST_W-1:0]  dist_top;
   logic signed [DIST_W-1:0]  dist_right;
   logic signed [DIST_W-1:0]  dist_bottom;

   modport source (
      output valid, class_logit, last_class, frame_start,
             dist_left, dist_top, dist_right, dist_bottom,
      input  ready
   );
   modport sink (
      input  valid, class_logit, last_class, frame_start,
             dist_left, dist_top, dist_right, dist_bottom,
      output ready
   );
endinterface

interface dhbd_rsp_if import dhbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [BOX_W-1:0]  box_x;
   logic signed [BOX_W-1:0]  box_y;
   logic signed [BOX_W-1:0]  box_w;
   logic signed [BOX_W-1:0]  box_h;
   logic [LABEL_W-1:0]       class_label;
   logic [SCORE_W-1:0]       score;

   modport source (
      output valid, box_x, box_y, box_w, box_h, class_label, score,
      input  ready
   );
   modport sink (
      input  valid, box_x, box_y, box_w, box_h, class_label, score,
      output ready
   );
endinterface

// File: design/detection_head_box_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_head_box_decoder
// Anchor-free box decoder for one stride level of a detection head.
// ----------------------------------------------------------------------------
// Each request carries one class logit of the current grid cell. The logit
// goes through a fixed-point sigmoid whose final step is a division done by a
// shared radix-2 divider, one quotient bit per cycle. A request whose sigmoid
// needs the divider passes the multiply, prepare, divide and update states
// and returns to idle before the next acceptance; a logit far enough out that
// the score saturates skips the divider. The block keeps the best score of the cell and
// its class index. On the request marked last_class, a box is sent on the
// response channel if the best score is strictly above score_threshold, and
// the column and row counters advance. A waiting response does not block new
// requests; a request only stalls when it has a box to send and the previous
// response is still held.
module detection_head_box_decoder import dhbd_pkg::*; #(
   parameter int MAX_CLASSES = MAX_CLASSES_DEF,
   parameter int MAX_GRID    = MAX_GRID_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dhbd_req_if.sink              req_if,
   dhbd_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int GRID_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [GW_W-1:0]     grid_width_ff;
   logic [STRIDE_W-1:0] cell_stride_ff;
   logic [SCORE_W-1:0]  score_threshold_ff;

   logic signed [LOGIT_W-1:0] logit_ff;
   logic                      last_ff;
   logic signed [DIST_W-1:0]  dist_left_ff;
   logic signed [DIST_W-1:0]  dist_top_ff;
   logic signed [DIST_W-1:0]  dist_right_ff;
   logic signed [DIST_W-1:0]  dist_bottom_ff;

   logic signed [S_W-1:0] s_ff, s_in;
   logic [SCORE_W-1:0]    score_ff;

   logic [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [LABEL_W-1:0] best_label_ff, best_label_in;
   logic [CLS_W-1:0]   class_cnt_ff,  class_cnt_in;
   logic [GRID_W-1:0]  col_ff;
   logic [GRID_W-1:0]  row_ff;
   logic [GRID_W-1:0]  col_in;
   logic [GRID_W-1:0]  row_in;

   logic                     rsp_valid_ff;
   logic signed [BOX_W-1:0]  box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [LABEL_W-1:0]       class_label_ff;
   logic [SCORE_W-1:0]       rsp_score_ff;

   expo_type           expo;
   logic               div_done;
   logic [QUO_W-1:0]   div_quo;
   logic signed [BOX_W-1:0] box_x, box_y, box_w, box_h;

   logic            req_fire;
   logic            emit;
   logic            advance;
   logic [GW_W-1:0] width_eff;
   logic [GW_W-1:0] col_plus;

   dhbd_expo u_expo (
      .s_arg (s_ff),
      .expo  (expo)
   );

   dhbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .den      (expo.den),
      .done     (div_done),
      .quotient (div_quo)
   );

   dhbd_box u_box (
      .col         (INDEX_W'(col_ff)),
      .row         (INDEX_W'(row_ff)),
      .stride      (cell_stride_ff),
      .dist_left   (dist_left_ff),
      .dist_top    (dist_top_ff),
      .dist_right  (dist_right_ff),
      .dist_bottom (dist_bottom_ff),
      .box_x       (box_x),
      .box_y       (box_y),
      .box_w       (box_w),
      .box_h       (box_h)
   );

   assign req_fire = req_if.valid && ctrl.req_ready;

   // Exponent argument of 2^(-x*log2e) with the float bias added.
   assign s_in = EXP_BIAS_X2 - (S_W'(logit_ff) * S_W'(LOG2E_Q16));

   always_comb begin
      if (score_ff > best_score_ff) begin
         best_score_in = score_ff;
         best_label_in = LABEL_W'(class_cnt_ff);
      end else begin
         best_score_in = best_score_ff;
         best_label_in = best_label_ff;
      end

      if (class_cnt_ff == CLS_W'(MAX_CLASSES - 1)) begin
         class_cnt_in = '0;
      end else begin
         class_cnt_in = class_cnt_ff + 1'b1;
      end

      // Grid widths of zero or above the counter range are clamped.
      priority if (grid_width_ff == '0) begin
         width_eff = GW_W'(1);
      end else if (grid_width_ff > GW_W'(MAX_GRID)) begin
         width_eff = GW_W'(MAX_GRID);
      end else begin
         width_eff = grid_width_ff;
      end

      col_plus = GW_W'(col_ff) + 1'b1;
      if (col_plus >= width_eff) begin
         col_in = '0;
         if (row_ff == GRID_W'(MAX_GRID - 1)) begin
            row_in = '0;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end else begin
         col_in = col_plus[GRID_W-1:0];
         row_in = row_ff;
      end

      emit    = last_ff && (best_score_in > score_threshold_ff);
      advance = !emit || !rsp_valid_ff || rsp_if.ready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = expo.bypass ? ST_UPD : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: ctrl.req_ready = 1'b1;
         ST_MUL:  ;
         ST_PREP: ctrl.div_start = !expo.bypass;
         ST_DIV:  ;
         ST_UPD:  ctrl.commit = advance;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         grid_width_ff      <= GRID_WIDTH_RESET;
         cell_stride_ff     <= CELL_STRIDE_RESET;
         score_threshold_ff <= SCORE_THRESHOLD_RESET;
         best_score_ff      <= '0;
         best_label_ff      <= '0;
         class_cnt_ff       <= '0;
         col_ff             <= '0;
         row_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:      grid_width_ff      <= csr_wdata[GW_W-1:0];
               CSR_CELL_STRIDE:     cell_stride_ff     <= csr_wdata[STRIDE_W-1:0];
               CSR_SCORE_THRESHOLD: score_threshold_ff <= csr_wdata[SCORE_W-1:0];
               default: ;
            endcase
         end

         // A frame start clears the cell and grid position before the
         // request is scored.
         if (req_fire && req_if.frame_start) begin
            best_score_ff <= '0;
            best_label_ff <= '0;
            class_cnt_ff  <= '0;
            col_ff        <= '0;
            row_ff        <= '0;
         end else if (ctrl.commit) begin
            if (last_ff) begin
               best_score_ff <= '0;
               best_label_ff <= '0;
               class_cnt_ff  <= '0;
               col_ff        <= col_in;
               row_ff        <= row_in;
            end else begin
               best_score_ff <= best_score_in;
               best_label_ff <= best_label_in;
               class_cnt_ff  <= class_cnt_in;
            end
         end

         if (ctrl.commit && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         logit_ff       <= req_if.class_logit;
         last_ff        <= req_if.last_class;
         dist_left_ff   <= req_if.dist_left;
         dist_top_ff    <= req_if.dist_top;
         dist_right_ff  <= req_if.dist_right;
         dist_bottom_ff <= req_if.dist_bottom;
      end

      if (state_ff == ST_MUL) begin
         s_ff <= s_in;
      end

      if (state_ff == ST_PREP && expo.bypass) begin
         score_ff <= expo.bypass_score;
      end else if (state_ff == ST_DIV && div_done) begin
         score_ff <= div_quo[QUO_W-1] ? SCORE_MAX : div_quo[SCORE_W-1:0];
      end

      if (ctrl.commit && emit) begin
         box_x_ff       <= box_x;
         box_y_ff       <= box_y;
         box_w_ff       <= box_w;
         box_h_ff       <= box_h;
         class_label_ff <= best_label_in;
         rsp_score_ff   <= best_score_in;
      end
   end

   // No request is taken while reset is held.
   assign req_if.ready       = ctrl.req_ready && !reset;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.box_x       = box_x_ff;
   assign rsp_if.box_y       = box_y_ff;
   assign rsp_if.box_w       = box_w_ff;
   assign rsp_if.box_h       = box_h_ff;
   assign rsp_if.class_label = class_label_ff;
   assign rsp_if.score       = rsp_score_ff;

endmodule

// File: design/dhbd_expo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbd_expo
// Decodes the sigmoid exponent argument into the divider denominator, or
// into a fixed score where the sigmoid saturates.
// ----------------------------------------------------------------------------
module dhbd_expo import dhbd_pkg::*; (
   input  logic signed [S_W-1:0] s_arg,
   output expo_type              expo
);

   logic [S_W-3:0]    bits;
   logic [EXP_W-1:0]  expn;
   logic [MANT_W-1:0] mant;
   logic [DEN_W-1:0]  mant_wide;
   logic [DEN_W-1:0]  mag;
   logic [EXP_W-1:0]  sh_left;
   logic [EXP_W-1:0]  sh_right;

   always_comb begin
      bits      = s_arg[S_W-2:1];
      expn      = bits[S_W-3:MANT_W-1];
      mant      = {1'b1, bits[MANT_W-2:0]};
      mant_wide = {{(DEN_W-MANT_W){1'b0}}, mant};
      sh_left   = expn - EXP_REF;
      sh_right  = EXP_REF - expn;

      if (expn >= EXP_REF) begin
         mag = mant_wide << sh_left[5:0];
      end else begin
         mag = mant_wide >> sh_right[4:0];
      end

      expo.den = (DEN_W'(1) << DEN_ONE) + mag;

      priority if (s_arg[S_W-1]) begin
         expo.bypass       = 1'b1;
         expo.bypass_score = SCORE_MAX;
      end else if (expn > EXP_HI) begin
         expo.bypass       = 1'b1;
         expo.bypass_score = '0;
      end else if (expn < EXP_LO) begin
         expo.bypass       = 1'b1;
         expo.bypass_score = SCORE_MAX;
      end else begin
         expo.bypass       = 1'b0;
         expo.bypass_score = '0;
      end
   end

endmodule

// File: design/dhbd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbd_div
// Restoring radix-2 divider that forms floor(2^56 / den), one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module dhbd_div import dhbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W-1:0]     rem_ff,  rem_in;
   logic [QUO_W-1:0]     quo_ff,  quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DEN_W:0]       shifted;
   logic [DEN_W:0]       diff;
   logic                 fits;

   // The remainder always stays below den, so the doubled value needs only
   // one bit more than den.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_in  = {quo_ff[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= DEN_W'(1) << REM_INIT;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/dhbd_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbd_box
// Forms the box corner and size from the cell position and the left, top,
// right and bottom edge distances, saturating the corner to the output range.
// ----------------------------------------------------------------------------
module dhbd_box import dhbd_pkg::*; (
   input  logic [INDEX_W-1:0]       col,
   input  logic [INDEX_W-1:0]       row,
   input  logic [STRIDE_W-1:0]      stride,
   input  logic signed [DIST_W-1:0] dist_left,
   input  logic signed [DIST_W-1:0] dist_top,
   input  logic signed [DIST_W-1:0] dist_right,
   input  logic signed [DIST_W-1:0] dist_bottom,
   output logic signed [BOX_W-1:0]  box_x,
   output logic signed [BOX_W-1:0]  box_y,
   output logic signed [BOX_W-1:0]  box_w,
   output logic signed [BOX_W-1:0]  box_h
);

   localparam int POS_W = INDEX_W + STRIDE_W + 4;

   function automatic logic signed [BOX_W-1:0] sat_box(
      input logic signed [BOX_CALC_W-1:0] v
   );
      logic signed [BOX_CALC_W-1:0] hi;
      logic signed [BOX_CALC_W-1:0] lo;
      hi = BOX_CALC_W'(65535);
      lo = -BOX_CALC_W'(65536);
      if (v > hi) begin
         return {1'b0, {(BOX_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(BOX_W-1){1'b0}}};
      end else begin
         return v[BOX_W-1:0];
      end
   endfunction

   logic [INDEX_W+STRIDE_W-1:0]  col_step;
   logic [INDEX_W+STRIDE_W-1:0]  row_step;
   logic [POS_W-1:0]             pos_x;
   logic [POS_W-1:0]             pos_y;
   logic signed [BOX_CALC_W-1:0] calc_x;
   logic signed [BOX_CALC_W-1:0] calc_y;

   always_comb begin
      col_step = (INDEX_W+STRIDE_W)'(col) * (INDEX_W+STRIDE_W)'(stride);
      row_step = (INDEX_W+STRIDE_W)'(row) * (INDEX_W+STRIDE_W)'(stride);
      pos_x    = {col_step, 4'b0000};
      pos_y    = {row_step, 4'b0000};
      calc_x   = $signed({{(BOX_CALC_W-POS_W){1'b0}}, pos_x})
               - $signed({{(BOX_CALC_W-DIST_W){dist_left[DIST_W-1]}}, dist_left});
      calc_y   = $signed({{(BOX_CALC_W-POS_W){1'b0}}, pos_y})
               - $signed({{(BOX_CALC_W-DIST_W){dist_top[DIST_W-1]}}, dist_top});
      box_x    = sat_box(calc_x);
      box_y    = sat_box(calc_y);
      // Sums of two 16-bit values always fit the 17-bit result.
      box_w    = {dist_left[DIST_W-1], dist_left} + {dist_right[DIST_W-1], dist_right};
      box_h    = {dist_top[DIST_W-1], dist_top} + {dist_bottom[DIST_W-1], dist_bottom};
   end

endmodule
